/* hdl/wgm_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the wildcard glob matcher.
package wgm_pkg;

  localparam logic [7:0] CH_ANY_ONE = 8'h3F;  // '?'
  localparam logic [7:0] CH_ANY_RUN = 8'h2A;  // '*'

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } wgm_op_t;

  // Broadcast controls shared by every cell in the row
  typedef struct packed {
    logic clear;    // drop the stored pattern
    logic restart;  // active set back to position zero
    logic step;     // advance on one text byte
  } wgm_cell_ctrl_t;

endpackage

/* hdl/wildcard_glob_match_unit.sv */
`timescale 1ns / 1ps
// Wildcard glob matcher: one position cell per pattern byte, one text byte per cycle while the input is not stalled.
// Throughput: one transaction per cycle for every operation, unless the input is stalled.
// The end-of-text result is registered into the output buffer; out_tvalid rises once it reaches the head entry.
// The rate is set by the closure carry chain across all cells plus one compare per cell.
// Two-entry output buffer; input stalls only when both entries are full.
// Synchronous active-low reset: empty pattern, no overflow, position zero active.
module wildcard_glob_match_unit #(
  parameter int unsigned MAX_PATTERN = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] character
  input  logic [1:0] in_tuser,   // [1:0] operation
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] matched, [1] pattern_overflow, [7:2] zero
);
  import wgm_pkg::*;

  localparam int unsigned NPOS  = MAX_PATTERN + 1;
  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);

  wgm_op_t        op;
  logic           acc;
  wgm_cell_ctrl_t ctrl;
  logic           room;

  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] len_nxt;
  logic             ovf_r;
  logic             ovf_nxt;
  logic             last_r;     // final position, past the last cell
  logic             last_nxt;

  logic [NPOS-1:0]        raw;
  logic [NPOS-1:0]        star;
  logic [NPOS-1:0]        closed;
  logic [MAX_PATTERN:0]   adv;
  logic [MAX_PATTERN-1:0] load;

  logic       push;
  logic       pop;
  logic [1:0] res;
  logic       head_v_r;
  logic       head_v_nxt;
  logic [1:0] head_r;
  logic [1:0] head_nxt;
  logic       skid_v_r;
  logic       skid_v_nxt;
  logic [1:0] skid_r;
  logic [1:0] skid_nxt;

  assign op   = wgm_op_t'(in_tuser);
  assign acc  = in_tvalid & in_tready;
  assign room = (len_r < LEN_W'(MAX_PATTERN));

  always_comb begin
    ctrl = '0;
    if (acc) begin
      case (op)
        OP_CLEAR: begin
          ctrl.clear   = 1'b1;
          ctrl.restart = 1'b1;
        end
        OP_APPEND: ctrl.restart = 1'b1;
        OP_TEXT:   ctrl.step    = 1'b1;
        OP_END:    ctrl.restart = 1'b1;
        default:   ctrl = '0;
      endcase
    end
  end

  assign adv[0]           = 1'b0;
  assign star[MAX_PATTERN] = 1'b0;
  assign raw[MAX_PATTERN]  = last_r;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    assign load[i] = acc & (op == OP_APPEND) & (len_r == LEN_W'(i));

    wgm_cell #(
      .FIRST(i == 0)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .load      (load[i]),
      .char_in   (in_tdata),
      .closed_in (closed[i]),
      .adv_in    (adv[i]),
      .adv_out   (adv[i+1]),
      .star_out  (star[i]),
      .active_out(raw[i])
    );
  end

  wgm_closure #(
    .NPOS(NPOS)
  ) u_closure (
    .raw   (raw),
    .star  (star),
    .closed(closed)
  );

  always_comb begin
    len_nxt  = len_r;
    ovf_nxt  = ovf_r;
    last_nxt = last_r;
    if (ctrl.clear) begin
      len_nxt = '0;
      ovf_nxt = 1'b0;
    end else if (acc && op == OP_APPEND) begin
      if (room) begin
        len_nxt = len_r + LEN_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (ctrl.restart) begin
      last_nxt = 1'b0;
    end else if (ctrl.step) begin
      last_nxt = adv[MAX_PATTERN];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      ovf_r  <= 1'b0;
      last_r <= 1'b0;
    end else begin
      len_r  <= len_nxt;
      ovf_r  <= ovf_nxt;
      last_r <= last_nxt;
    end
  end

  // result: {pattern_overflow, matched}
  assign res  = {ovf_r, closed[len_r] & ~ovf_r};
  assign push = acc & (op == OP_END);
  assign pop  = head_v_r & out_tready;

  always_comb begin
    head_v_nxt = head_v_r;
    head_nxt   = head_r;
    skid_v_nxt = skid_v_r;
    skid_nxt   = skid_r;
    if (pop) begin
      if (skid_v_r) begin
        head_nxt   = skid_r;
        skid_v_nxt = push;
        skid_nxt   = res;
      end else begin
        head_v_nxt = push;
        head_nxt   = res;
      end
    end else if (push) begin
      if (!head_v_r) begin
        head_v_nxt = 1'b1;
        head_nxt   = res;
      end else begin
        skid_v_nxt = 1'b1;
        skid_nxt   = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign in_tready  = ~skid_v_r;
  assign out_tvalid = head_v_r;
  assign out_tdata  = {6'b0, head_r};

endmodule

/* hdl/wgm_cell.sv */
`timescale 1ns / 1ps
// One pattern position: stored byte, in-use bit and raw active bit.
module wgm_cell #(
  parameter bit FIRST = 1'b0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  wgm_pkg::wgm_cell_ctrl_t ctrl,
  input  logic                    load,
  input  logic [7:0]              char_in,
  input  logic                    closed_in,  // closed active bit for this position
  input  logic                    adv_in,     // match carried from previous cell
  output logic                    adv_out,    // match carried to next cell
  output logic                    star_out,   // in use and holds '*'
  output logic                    active_out
);
  import wgm_pkg::*;

  logic [7:0] byte_r;
  logic       used_r;
  logic       used_nxt;
  logic       active_r;
  logic       active_nxt;
  logic       hit;

  assign star_out   = used_r & (byte_r == CH_ANY_RUN);
  assign hit        = (byte_r == CH_ANY_ONE) | (byte_r == char_in);
  assign adv_out    = closed_in & used_r & ~star_out & hit;
  assign active_out = active_r;

  always_comb begin
    used_nxt = used_r;
    if (ctrl.clear) begin
      used_nxt = 1'b0;
    end else if (load) begin
      used_nxt = 1'b1;
    end
  end

  always_comb begin
    active_nxt = active_r;
    if (ctrl.restart) begin
      active_nxt = FIRST;
    end else if (ctrl.step) begin
      // '*' keeps itself alive; otherwise take what the left neighbour hands on
      active_nxt = (closed_in & star_out) | adv_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= 1'b0;
      active_r <= FIRST;
    end else begin
      used_r   <= used_nxt;
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= char_in;
    end
  end

endmodule

/* hdl/wgm_closure.sv */
`timescale 1ns / 1ps
// Star closure of the active set, done as one carry chain (adder).
module wgm_closure #(
  parameter int unsigned NPOS = 65
) (
  input  logic [NPOS-1:0] raw,
  input  logic [NPOS-1:0] star,
  output logic [NPOS-1:0] closed
);
  logic [NPOS-1:0] gen;
  logic [NPOS:0]   sum;
  logic [NPOS-1:0] carry;

  // generate where an active '*' sits, propagate through every '*'
  assign gen    = raw & star;
  assign sum    = {1'b0, star} + {1'b0, gen};
  assign carry  = sum[NPOS-1:0] ^ star ^ gen;
  assign closed = raw | carry;

endmodule
